// File: sv/spm_pkg.sv
// Shared constants, types and codes for the shortest path matrix block.
`timescale 1ns / 1ps
package spm_pkg;

  localparam int MAX_NODES   = 16;
  localparam int WEIGHT_BITS = 16;
  localparam int DIST_BITS   = 20;
  localparam int NODE_BITS   = $clog2(MAX_NODES);
  localparam int CNT_BITS    = $clog2(MAX_NODES + 1);
  localparam int ADDR_BITS   = $clog2(MAX_NODES * MAX_NODES);
  localparam int SUM_BITS    = ((DIST_BITS > WEIGHT_BITS) ? DIST_BITS : WEIGHT_BITS) + 1;

  localparam logic [DIST_BITS-1:0] DIST_LIMIT = '1;

  localparam logic [4:0] NODE_COUNT_RESET = 5'd16;

  // Register index, taken from the word address of the configuration port.
  localparam logic CFG_NODE_COUNT = 1'b0;

  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_RELAX,
    S_DONE
  } search_state_t;

  typedef struct packed {
    logic                 go;
    logic                 bad;
    logic [NODE_BITS-1:0] src;
    logic [NODE_BITS-1:0] dst;
    logic [CNT_BITS-1:0]  cnt;
  } search_cmd_t;

  typedef struct packed {
    logic                 busy;
    logic                 done;
    logic [DIST_BITS-1:0] distance;
    logic                 reach;
  } search_res_t;

endpackage

// File: sv/spm_wstore.sv
// Edge weight memory with one valid bit per entry, cleared at reset.
`timescale 1ns / 1ps
module spm_wstore
  import spm_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   wr_en,
  input  logic [ADDR_BITS-1:0]   wr_addr,
  input  logic [WEIGHT_BITS-1:0] wr_data,
  input  logic [ADDR_BITS-1:0]   rd_addr,
  output logic [WEIGHT_BITS-1:0] rd_data
);

  localparam int DEPTH = MAX_NODES * MAX_NODES;

  logic [WEIGHT_BITS-1:0] mem [DEPTH];
  logic [DEPTH-1:0]       valid;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (wr_en) begin
      valid[wr_addr] <= 1'b1;
    end
  end

  // An entry never written reads as no edge.
  always_ff @(posedge clk) begin
    rd_data <= valid[rd_addr] ? mem[rd_addr] : '0;
  end

endmodule

// File: sv/spm_alu.sv
// Shared saturating add and less-than compare used by node selection and relaxation.
`timescale 1ns / 1ps
module spm_alu
  import spm_pkg::*;
(
  input  logic [DIST_BITS-1:0]   a,
  input  logic [WEIGHT_BITS-1:0] w,
  input  logic [DIST_BITS-1:0]   b,
  output logic [DIST_BITS-1:0]   sum,
  output logic                   less
);

  logic [SUM_BITS-1:0] raw;

  always_comb begin
    raw  = SUM_BITS'(a) + SUM_BITS'(w);
    sum  = (raw > SUM_BITS'(DIST_LIMIT)) ? DIST_LIMIT : raw[DIST_BITS-1:0];
    less = sum < b;
  end

endmodule

// File: sv/spm_search.sv
// Search sequencer: alternates a least-distance scan and an edge relaxation pass.
`timescale 1ns / 1ps
module spm_search
  import spm_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  search_cmd_t            cmd,
  input  logic                   res_take,
  output logic [ADDR_BITS-1:0]   rd_addr,
  input  logic [WEIGHT_BITS-1:0] rd_data,
  output search_res_t            res
);

  search_state_t state, state_next;

  logic [DIST_BITS-1:0] node_dist [MAX_NODES];
  logic [MAX_NODES-1:0] settled;
  logic [MAX_NODES-1:0] known;
  logic [CNT_BITS-1:0]  idx;
  logic                 found;
  logic [NODE_BITS-1:0] pick;
  logic [DIST_BITS-1:0] pick_dist;
  logic                 upd_valid;
  logic [NODE_BITS-1:0] upd_idx;
  logic                 bad;
  logic [NODE_BITS-1:0] dst;
  logic [CNT_BITS-1:0]  cnt;

  logic [NODE_BITS-1:0]   cur;
  logic                   at_end;
  logic                   cand;
  logic [DIST_BITS-1:0]   alu_a;
  logic [WEIGHT_BITS-1:0] alu_w;
  logic [DIST_BITS-1:0]   alu_b;
  logic [DIST_BITS-1:0]   alu_sum;
  logic                   alu_less;
  logic                   relax_hit;

  assign cur    = idx[NODE_BITS-1:0];
  assign at_end = (idx == cnt);

  // During the scan the unit compares a candidate with the best so far;
  // during relaxation it adds the edge weight and compares with the target.
  always_comb begin
    if (state == S_SCAN) begin
      alu_a = node_dist[cur];
      alu_w = '0;
      alu_b = pick_dist;
    end else begin
      alu_a = pick_dist;
      alu_w = rd_data;
      alu_b = node_dist[upd_idx];
    end
  end

  spm_alu u_alu (
    .a    (alu_a),
    .w    (alu_w),
    .b    (alu_b),
    .sum  (alu_sum),
    .less (alu_less)
  );

  assign cand = known[cur] && !settled[cur] && (!found || alu_less);
  assign relax_hit = upd_valid && (rd_data != '0) && !settled[upd_idx] &&
                     (!known[upd_idx] || alu_less);
  assign rd_addr = ADDR_BITS'(pick) * ADDR_BITS'(MAX_NODES) + ADDR_BITS'(cur);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (cmd.go) begin
          state_next = cmd.bad ? S_DONE : S_SCAN;
        end
      end
      S_SCAN: begin
        if (at_end) begin
          if (!found || pick == dst) begin
            state_next = S_DONE;
          end else begin
            state_next = S_RELAX;
          end
        end
      end
      S_RELAX: begin
        if (at_end && !upd_valid) begin
          state_next = S_SCAN;
        end
      end
      S_DONE: begin
        if (res_take) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (cmd.go) begin
          bad       <= cmd.bad;
          dst       <= cmd.dst;
          cnt       <= cmd.cnt;
          settled   <= '0;
          known     <= MAX_NODES'(1) << cmd.src;
          node_dist[cmd.src] <= '0;
          idx       <= '0;
          found     <= 1'b0;
          upd_valid <= 1'b0;
        end
      end
      S_SCAN: begin
        if (!at_end) begin
          if (cand) begin
            pick      <= cur;
            pick_dist <= node_dist[cur];
            found     <= 1'b1;
          end
          idx <= idx + CNT_BITS'(1);
        end else begin
          if (found) begin
            settled[pick] <= 1'b1;
          end
          idx <= '0;
        end
      end
      S_RELAX: begin
        if (!at_end) begin
          upd_valid <= 1'b1;
          upd_idx   <= cur;
          idx       <= idx + CNT_BITS'(1);
        end else begin
          upd_valid <= 1'b0;
          if (!upd_valid) begin
            idx   <= '0;
            found <= 1'b0;
          end
        end
        if (relax_hit) begin
          node_dist[upd_idx] <= alu_sum;
          known[upd_idx]     <= 1'b1;
        end
      end
      S_DONE: begin
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    res.busy     = (state != S_IDLE);
    res.done     = (state == S_DONE);
    res.reach    = !bad && known[dst];
    res.distance = res.reach ? node_dist[dst] : '0;
  end

endmodule

// File: sv/shortest_path_matrix.sv
// Shortest path block: register port, item handshake, result register and search core.
// An edge write item is stored when it is taken. A query item runs, for each node
// settled, a selection scan and a relaxation pass over the first count nodes, which
// share the single compare/add unit; the weight memory is read through one port. No
// new item is taken until the query result has been taken by the output register.
// Reset clears node_count to 16 and marks every weight entry as no edge.
`timescale 1ns / 1ps
module shortest_path_matrix
  import spm_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        req_type,
  input  logic [3:0]  row_node,
  input  logic [3:0]  col_node,
  input  logic [15:0] edge_weight,
  input  logic [3:0]  start_node,
  input  logic [3:0]  finish_node,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [19:0] path_distance,
  output logic        reachable
);

  logic [4:0]             node_count;
  logic [CNT_BITS-1:0]    cnt_eff;
  logic                   in_take;
  logic                   wr_en;
  logic [ADDR_BITS-1:0]   wr_addr;
  logic [ADDR_BITS-1:0]   rd_addr;
  logic [WEIGHT_BITS-1:0] rd_data;
  search_cmd_t            cmd;
  search_res_t            res;
  logic                   res_take;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      node_count <= NODE_COUNT_RESET;
    end else if (psel && penable && pwrite && pready && paddr[2] == CFG_NODE_COUNT) begin
      node_count <= pwdata[4:0];
    end
  end

  assign prdata = (paddr[2] == CFG_NODE_COUNT) ? {27'd0, node_count} : 32'd0;

  always_comb begin
    if (node_count == 5'd0) begin
      cnt_eff = CNT_BITS'(1);
    end else if (int'(node_count) > MAX_NODES) begin
      cnt_eff = CNT_BITS'(MAX_NODES);
    end else begin
      cnt_eff = CNT_BITS'(node_count);
    end
  end

  assign in_ready = !res.busy;
  assign in_take  = in_valid && in_ready;

  assign wr_en   = in_take && (req_type == REQ_WRITE) &&
                   (int'(row_node) < MAX_NODES) && (int'(col_node) < MAX_NODES);
  assign wr_addr = ADDR_BITS'(row_node) * ADDR_BITS'(MAX_NODES) + ADDR_BITS'(col_node);

  spm_wstore u_wstore (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (WEIGHT_BITS'(edge_weight)),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_comb begin
    cmd.go  = in_take && (req_type == REQ_QUERY);
    cmd.bad = (int'(start_node) >= int'(cnt_eff)) || (int'(finish_node) >= int'(cnt_eff));
    cmd.src = NODE_BITS'(start_node);
    cmd.dst = NODE_BITS'(finish_node);
    cmd.cnt = cnt_eff;
  end

  spm_search u_search (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .res_take (res_take),
    .rd_addr  (rd_addr),
    .rd_data  (rd_data),
    .res      (res)
  );

  assign res_take = res.done && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_take) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      path_distance <= res.distance;
      reachable     <= res.reach;
    end
  end

endmodule
